// ----- rtl/utf8d_pkg.sv -----
// shared types and constants for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  localparam logic [CpW-1:0]  CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0]  SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0]  SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0]  ReplReset   = 21'h00FFFD;

  localparam logic [LenW-1:0] LenNone     = 3'd0;
  localparam logic [LenW-1:0] LenOne      = 3'd1;
  localparam logic [LenW-1:0] LenTwo      = 3'd2;
  localparam logic [LenW-1:0] LenThree    = 3'd3;
  localparam logic [LenW-1:0] LenFour     = 3'd4;

  // results caused by one request: a run of errors, then an optional good result
  typedef struct packed {
    logic [LenW-1:0] n_err;
    logic            has_val;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
  } burst_t;

  // smallest scalar value that a sequence of the given length may encode
  function automatic logic [CpW-1:0] min_cp(input logic [LenW-1:0] len);
    logic [CpW-1:0] m;
    case (len)
      LenTwo:   m = 21'h000080;
      LenThree: m = 21'h000800;
      LenFour:  m = 21'h010000;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/utf8d_decode.sv -----
// sequence state and single-pass decode of one byte into a result burst
module utf8d_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_text,
  output utf8d_pkg::burst_t burst
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  pv_r, pv_nxt;
  logic [LenW-1:0] el_r, el_nxt;
  logic [LenW-1:0] br_r, br_nxt;

  logic            is_cont;
  logic            seq_open;
  logic [CpW-1:0]  pv_cat;
  logic [LenW-1:0] br_inc;
  logic            bad_cp;

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign seq_open = (el_r != LenNone);
  assign pv_cat   = {pv_r[CpW-7:0], in_byte[5:0]};
  assign br_inc   = br_r + LenOne;
  assign bad_cp   = (pv_cat < min_cp(el_r)) || (pv_cat > CpMax) ||
                    ((pv_cat >= SurrLo) && (pv_cat <= SurrHi));

  // decode of the byte against the open sequence
  always_comb begin
    pv_nxt        = pv_r;
    el_nxt        = el_r;
    br_nxt        = br_r;
    burst.n_err   = '0;
    burst.has_val = 1'b0;
    burst.cp      = pv_cat;
    burst.len     = el_r;
    if (seq_open && is_cont) begin
      pv_nxt = pv_cat;
      br_nxt = br_inc;
      if (br_inc >= el_r) begin
        if (bad_cp) begin
          burst.n_err = el_r;
        end else begin
          burst.has_val = 1'b1;
        end
        pv_nxt = '0;
        el_nxt = LenNone;
        br_nxt = '0;
      end else if (in_end_of_text) begin
        burst.n_err = br_inc;
        pv_nxt = '0;
        el_nxt = LenNone;
        br_nxt = '0;
      end
    end else begin
      // a breaking byte flushes the pending bytes, then counts as a lead byte
      if (seq_open) begin
        burst.n_err = br_r;
      end
      pv_nxt = '0;
      el_nxt = LenNone;
      br_nxt = '0;
      case (in_byte) inside
        [8'h00:8'h7F]: begin
          burst.has_val = 1'b1;
          burst.cp      = {{(CpW-8){1'b0}}, in_byte};
          burst.len     = LenOne;
        end
        [8'hC2:8'hDF]: begin
          pv_nxt = {{(CpW-5){1'b0}}, in_byte[4:0]};
          el_nxt = LenTwo;
          br_nxt = LenOne;
        end
        [8'hE0:8'hEF]: begin
          pv_nxt = {{(CpW-4){1'b0}}, in_byte[3:0]};
          el_nxt = LenThree;
          br_nxt = LenOne;
        end
        [8'hF0:8'hF4]: begin
          pv_nxt = {{(CpW-3){1'b0}}, in_byte[2:0]};
          el_nxt = LenFour;
          br_nxt = LenOne;
        end
        default: begin
          burst.n_err = burst.n_err + LenOne;
        end
      endcase
      // lead byte cut off at end of text
      if (in_end_of_text && (el_nxt != LenNone)) begin
        burst.n_err = burst.n_err + LenOne;
        pv_nxt = '0;
        el_nxt = LenNone;
        br_nxt = '0;
      end
    end
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      el_r <= LenNone;
      br_r <= '0;
    end else if (accept) begin
      pv_r <= pv_nxt;
      el_r <= el_nxt;
      br_r <= br_nxt;
    end
  end

endmodule

// ----- rtl/utf8d_out_seq.sv -----
// result register playing out a burst, one result per out_ready cycle
module utf8d_out_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  utf8d_pkg::burst_t        burst,
  input  logic [utf8d_pkg::CpW-1:0] repl,
  output logic                     busy,
  output logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [utf8d_pkg::CpW-1:0] out_codepoint,
  output logic [utf8d_pkg::LenW-1:0] out_byte_count,
  output logic                     out_valid_res,
  output logic                     out_last_of_run
);
  import utf8d_pkg::*;

  logic [LenW-1:0] err_left_r, err_left_nxt;
  logic            has_val_r, has_val_nxt;
  logic [CpW-1:0]  cp_r;
  logic [LenW-1:0] len_r;
  logic            in_err;
  logic            pop;

  assign in_err = (err_left_r != '0);
  assign busy   = in_err || has_val_r;
  assign last   = in_err ? ((err_left_r == LenOne) && !has_val_r) : has_val_r;
  assign pop    = busy && out_ready;

  // current result
  assign out_valid       = busy;
  assign out_codepoint   = in_err ? repl : cp_r;
  assign out_byte_count  = in_err ? LenOne : len_r;
  assign out_valid_res   = !in_err;
  assign out_last_of_run = last;

  // next burst state: load a new burst or step through the current one
  always_comb begin
    err_left_nxt = err_left_r;
    has_val_nxt  = has_val_r;
    if (load) begin
      err_left_nxt = burst.n_err;
      has_val_nxt  = burst.has_val;
    end else if (pop) begin
      if (in_err) begin
        err_left_nxt = err_left_r - LenOne;
      end else begin
        has_val_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_left_r <= '0;
      has_val_r  <= 1'b0;
    end else begin
      err_left_r <= err_left_nxt;
      has_val_r  <= has_val_nxt;
    end
  end

  // payload of the good result
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= burst.cp;
      len_r <= burst.len;
    end
  end

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// utf-8 stream decoder: validates text bytes and emits code points or errors
// first result: appears in the cycle after the request is accepted
// throughput: one request per cycle while out_ready is high and each request yields
//   at most one result; one with more holds the result register until all are taken
// reset: rst_n synchronous, clears the open sequence and pending results,
//   and sets the replacement code point to 0xFFFD
module utf8_stream_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CpW-1:0]  out_codepoint,
  output logic [utf8d_pkg::LenW-1:0] out_byte_count,
  output logic                       out_valid_res,
  output logic                       out_last_of_run,
  input  logic                       cfg_wr_en,
  input  logic [utf8d_pkg::CpW-1:0]  cfg_wr_data
);
  import utf8d_pkg::*;

  logic [CpW-1:0] repl_r;
  logic           accept;
  logic           load;
  logic           busy;
  logic           last;
  burst_t         burst;

  // replacement code point register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= ReplReset;
    end else if (cfg_wr_en) begin
      repl_r <= cfg_wr_data;
    end
  end

  // take a request when the result register is free or frees this cycle
  assign in_ready = !busy || (out_ready && last);
  assign accept   = in_valid && in_ready;
  assign load     = accept && ((burst.n_err != '0) || burst.has_val);

  utf8d_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .burst          (burst)
  );

  utf8d_out_seq u_out_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .burst           (burst),
    .repl            (repl_r),
    .busy            (busy),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_codepoint   (out_codepoint),
    .out_byte_count  (out_byte_count),
    .out_valid_res   (out_valid_res),
    .out_last_of_run (out_last_of_run)
  );

  // an idle result register never blocks a request
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // error results carry the replacement value and count one byte
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> ((out_codepoint == repl_r) && (out_byte_count == LenOne)))
    else $error("error result with wrong fields");

  // a run continues after a result that is not its last
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("run ended without last marker");

  // a good result always closes its run
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> out_last_of_run)
    else $error("good result not last of run");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the utf-8 stream decoder
module testbench;
  import utf8d_pkg::*;

  localparam int HoldCycles = 48;
  localparam int ErrPrintMax = 20;

  // one decoded result as it leaves the block
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] cnt;
    logic            ok;
    logic            last;
  } cp_result_t;

  // one request on the byte channel
  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  // shapes of random text
  typedef enum int {
    SEQ_GOOD,
    SEQ_TRUNC,
    SEQ_BADCONT,
    SEQ_OVERLONG,
    SEQ_SURR,
    SEQ_HIGH,
    SEQ_STRAY,
    SEQ_NOISE
  } seq_kind_e;

  // directed text: bit 8 marks end of text
  localparam logic [8:0] DirText [28] = '{
    9'h000, 9'h07F,                       // ascii extremes
    9'h0C2, 9'h080,                       // smallest two-byte value
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,       // largest scalar value
    9'h080,                               // stray continuation
    9'h0E0, 9'h080, 9'h080,               // overlong three-byte form
    9'h0ED, 9'h0A0, 9'h080,               // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080,       // above the unicode range
    9'h0C2, 9'h041,                       // missing continuation
    9'h0E2, 9'h182,                       // cut off at end of text
    9'h1F0,                               // lead byte that ends the text
    9'h0F0, 9'h090, 9'h080, 9'h041        // three errors then ascii
  };

  // expected results of the decoder, kept in request order
  class utf8_scoreboard;
    logic [CpW-1:0]  repl;
    logic [CpW-1:0]  acc;
    logic [LenW-1:0] seq_len;
    logic [LenW-1:0] seen;
    cp_result_t      cp_due_q[$];
    cp_result_t      step_q[$];
    int              n_bytes;
    int              n_results;
    int              n_good;
    int              n_bad;
    int              n_multi;
    int              widest;

    function new();
      repl      = ReplReset;
      acc       = '0;
      seq_len   = LenNone;
      seen      = '0;
      n_bytes   = 0;
      n_results = 0;
      n_good    = 0;
      n_bad     = 0;
      n_multi   = 0;
      widest    = 0;
    endfunction

    function void set_replacement(input logic [CpW-1:0] v);
      repl = v;
    endfunction

    function int pending();
      return cp_due_q.size();
    endfunction

    function void emit(input logic [CpW-1:0] cp, input logic [LenW-1:0] cnt, input logic ok);
      cp_result_t r;
      if (step_q.size() < 4) begin
        r.cp   = cp;
        r.cnt  = cnt;
        r.ok   = ok;
        r.last = 1'b0;
        step_q.push_back(r);
      end
    endfunction

    function void emit_errors(input logic [LenW-1:0] k);
      for (int i = 0; i < int'(k); i++) emit(repl, LenOne, 1'b0);
    endfunction

    function void drop_seq();
      acc     = '0;
      seq_len = LenNone;
      seen    = '0;
    endfunction

    function void open_seq(input logic [LenW-1:0] len, input logic [CpW-1:0] v);
      seq_len = len;
      acc     = v;
      seen    = LenOne;
    endfunction

    // works out the results of one accepted byte and queues them
    function void decode_byte(input logic [7:0] b, input logic eot);
      logic           need_lead;
      logic [CpW-1:0] floor_cp;
      cp_result_t     r;
      step_q.delete();
      need_lead = 1'b1;
      n_bytes++;
      // an open sequence takes continuation bytes, anything else breaks it
      if (seq_len != LenNone) begin
        if (b[7:6] == 2'b10) begin
          need_lead = 1'b0;
          acc = {acc[CpW-7:0], b[5:0]};
          seen = seen + 1'b1;
          if (seen >= seq_len) begin
            case (seq_len)
              LenTwo:   floor_cp = 21'h000080;
              LenThree: floor_cp = 21'h000800;
              LenFour:  floor_cp = 21'h010000;
              default:  floor_cp = '0;
            endcase
            // overlong, surrogate or out of range fails every byte
            if (acc < floor_cp || acc > CpMax || (acc >= SurrLo && acc <= SurrHi)) begin
              emit_errors(seq_len);
            end else begin
              emit(acc, seq_len, 1'b1);
            end
            drop_seq();
          end else if (eot) begin
            emit_errors(seen);
            drop_seq();
          end
        end else begin
          emit_errors(seen);
          drop_seq();
        end
      end
      // lead byte: ascii, opener of a longer sequence, or invalid
      if (need_lead) begin
        if (b < 8'h80) begin
          emit(CpW'(b), LenOne, 1'b1);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          open_seq(LenTwo, CpW'(b[4:0]));
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          open_seq(LenThree, CpW'(b[3:0]));
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          open_seq(LenFour, CpW'(b[2:0]));
        end else begin
          emit_errors(LenOne);
        end
        if (eot && seq_len != LenNone) begin
          emit_errors(seen);
          drop_seq();
        end
      end
      // mark the final result of this request
      if (step_q.size() > 0) begin
        r = step_q.pop_back();
        r.last = 1'b1;
        step_q.push_back(r);
        if (step_q.size() > 1) n_multi++;
        if (step_q.size() > widest) widest = step_q.size();
      end
      foreach (step_q[i]) cp_due_q.push_back(step_q[i]);
    endfunction

    // compares one result with the oldest one due, empty string on a match
    function string check_result(input cp_result_t got_r);
      cp_result_t want;
      string      diff;
      diff = "";
      n_results++;
      if (cp_due_q.size() == 0) begin
        return $sformatf("result %0d with nothing due: cp %h count %0d ok %0d last %0d",
                         n_results, got_r.cp, got_r.cnt, got_r.ok, got_r.last);
      end
      want = cp_due_q.pop_front();
      if (got_r.cp !== want.cp)
        diff = {diff, $sformatf(" codepoint %h want %h", got_r.cp, want.cp)};
      if (got_r.cnt !== want.cnt)
        diff = {diff, $sformatf(" byte_count %0d want %0d", got_r.cnt, want.cnt)};
      if (got_r.ok !== want.ok)
        diff = {diff, $sformatf(" valid_res %b want %b", got_r.ok, want.ok)};
      if (got_r.last !== want.last)
        diff = {diff, $sformatf(" last_of_run %b want %b", got_r.last, want.last)};
      if (want.ok) n_good++;
      else n_bad++;
      if (diff != "") return $sformatf("result %0d:%s", n_results, diff);
      return "";
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_byte;
  logic                in_end_of_text;
  logic                out_valid;
  logic                out_ready;
  logic [CpW-1:0]      out_codepoint;
  logic [LenW-1:0]     out_byte_count;
  logic                out_valid_res;
  logic                out_last_of_run;
  logic                cfg_wr_en;
  logic [CpW-1:0]      cfg_wr_data;

  utf8_scoreboard      cp_board;
  text_item_t          text_q[$];
  logic [7:0]          seq_q[$];
  int                  err_count;
  int                  n_cfg;
  int                  holds_done;
  bit                  src_idle;
  bit                  sink_idle;
  bit                  hold_out;

  utf8_stream_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_codepoint   (out_codepoint),
    .out_byte_count  (out_byte_count),
    .out_valid_res   (out_valid_res),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < ErrPrintMax) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    string msg;
    if (rst_n) begin
      if (cfg_wr_en) cp_board.set_replacement(cfg_wr_data);
      if (out_valid && out_ready) begin
        msg = cp_board.check_result(cp_result_t'{out_codepoint, out_byte_count,
                                                  out_valid_res, out_last_of_run});
        if (msg != "") report_mismatch(msg);
      end
      if (in_valid && in_ready) cp_board.decode_byte(in_byte, in_end_of_text);
    end
  end

  function automatic void put_text(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.b   = b;
    it.eot = eot;
    text_q.push_back(it);
  endfunction

  // utf-8 form of a value at a chosen length, no range checks
  function automatic void encode_cp(input logic [CpW-1:0] cp, input int len);
    seq_q.delete();
    case (len)
      1: seq_q.push_back({1'b0, cp[6:0]});
      2: begin
        seq_q.push_back({3'b110, cp[10:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_q.push_back({4'b1110, cp[15:12]});
        seq_q.push_back({2'b10, cp[11:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_q.push_back({5'b11110, cp[20:18]});
        seq_q.push_back({2'b10, cp[17:12]});
        seq_q.push_back({2'b10, cp[11:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // legal scalar value for a length, ends of the range now and then
  function automatic logic [CpW-1:0] pick_cp(input int len);
    int lo;
    int hi;
    int r;
    logic [CpW-1:0] cp;
    case (len)
      1:       begin lo = 0;       hi = 'h7F;     end
      2:       begin lo = 'h80;    hi = 'h7FF;    end
      3:       begin lo = 'h800;   hi = 'hFFFF;   end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    r = $urandom_range(0, 7);
    if (r == 0) return CpW'(lo);
    if (r == 1) return CpW'(hi);
    cp = CpW'($urandom_range(lo, hi));
    if (cp >= SurrLo && cp <= SurrHi) cp = cp ^ 21'h002000;
    return cp;
  endfunction

  // mostly well-formed text with random content, the rest broken or noise
  task automatic random_text(input int n_items);
    seq_kind_e  kind;
    int         pick;
    int         len;
    int         k;
    logic [7:0] b;
    while (text_q.size() < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) kind = SEQ_GOOD;
      else if (pick < 88) kind = seq_kind_e'($urandom_range(SEQ_TRUNC, SEQ_STRAY));
      else kind = SEQ_NOISE;
      len = $urandom_range(2, 4);
      case (kind)
        SEQ_GOOD: begin
          len = $urandom_range(1, 4);
          encode_cp(pick_cp(len), len);
        end
        SEQ_TRUNC: begin
          encode_cp(pick_cp(len), len);
          k = $urandom_range(1, len - 1);
          repeat (k) void'(seq_q.pop_back());
        end
        SEQ_BADCONT: begin
          encode_cp(pick_cp(len), len);
          k = $urandom_range(1, len - 1);
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          seq_q[k] = b;
        end
        SEQ_OVERLONG: begin
          case (len)
            2:       encode_cp(CpW'($urandom_range(0, 'h7F)), 2);
            3:       encode_cp(CpW'($urandom_range(0, 'h7FF)), 3);
            default: encode_cp(CpW'($urandom_range(0, 'hFFFF)), 4);
          endcase
        end
        SEQ_SURR: encode_cp(CpW'($urandom_range(SurrLo, SurrHi)), 3);
        SEQ_HIGH: encode_cp(CpW'($urandom_range(CpMax + 1, 'h1FFFFF)), 4);
        SEQ_STRAY: begin
          seq_q.delete();
          repeat ($urandom_range(1, 3)) seq_q.push_back(8'($urandom_range('h80, 'hBF)));
        end
        default: begin
          seq_q.delete();
          seq_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      // end of text lands on the last byte of some sequences
      foreach (seq_q[i])
        put_text(seq_q[i], (i == seq_q.size() - 1) && ($urandom_range(0, 7) == 0));
    end
  endtask

  // offer one request, holding it until taken
  task automatic send_item(input text_item_t it);
    int pause;
    pause = src_idle ? $urandom_range(0, 3) : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= it.b;
    in_end_of_text <= it.eot;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_item(text_q.pop_front());
    in_valid <= 1'b0;
  endtask

  // wait for every due result, then for bytes that leave nothing to show
  task automatic settle();
    @(posedge clk);
    while (cp_board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_replacement(input logic [CpW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_cfg++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int pause;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
        holds_done++;
      end
      pause = sink_idle ? $urandom_range(0, 3) : 0;
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int guard;
    cp_board       = new();
    err_count      = 0;
    n_cfg          = 0;
    holds_done     = 0;
    hold_out       = 1'b0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_byte        <= '0;
    in_end_of_text <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed then random text at the reset replacement value
    foreach (DirText[i]) put_text(DirText[i][7:0], DirText[i][8]);
    send_text();
    random_text(100);
    send_text();
    settle();

    // zero replacement, sender never idles
    write_replacement('0);
    src_idle = 1'b0;
    random_text(100);
    send_text();
    settle();

    // top of the range with a long output stall so the input backs up
    write_replacement(CpMax);
    hold_out = 1'b1;
    random_text(100);
    send_text();
    settle();

    // replacement above the range, no idling on either side
    write_replacement('1);
    sink_idle = 1'b0;
    random_text(100);
    send_text();
    settle();

    // random replacement, both sides idle again
    write_replacement(CpW'($urandom_range(0, CpMax)));
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    random_text(100);
    send_text();

    // drain and watch for stray results
    guard = 0;
    @(posedge clk);
    while (cp_board.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (cp_board.pending() != 0)
      report_mismatch($sformatf("%0d results due but never delivered", cp_board.pending()));

    $display("covered %0d bytes and %0d results: %0d decoded, %0d replaced, %0d settings",
             cp_board.n_bytes, cp_board.n_results, cp_board.n_good, cp_board.n_bad, n_cfg + 1);
    $display("bytes with several results: %0d, most from one byte: %0d, long stalls: %0d",
             cp_board.n_multi, cp_board.widest, holds_done);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_out_seq.sv
rtl/utf8_stream_decoder.sv
tb/sv/testbench.sv
